// ----- rtl/dbm_pkg.sv -----
// shared types and constants for the detection box map-back block
package dbm_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam logic [2:0] CFG_NORMALIZED = 3'd0;
    localparam logic [2:0] CFG_IMG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_IMG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_VALID_LOW  = 3'd3;
    localparam logic [2:0] CFG_VALID_HIGH = 3'd4;
    localparam logic [2:0] CFG_OFFSET     = 3'd5;
    localparam logic [2:0] CFG_RATIO      = 3'd6;

    localparam logic [63:0] RATIO_RESET = 64'h0001_0000_0001_0000;

    typedef struct packed {
        logic signed [31:0] box_left;
        logic signed [31:0] box_top;
        logic signed [31:0] box_right;
        logic signed [31:0] box_bottom;
        logic        [9:0]  class_tag;
    } box_t;

    typedef struct packed {
        logic signed [31:0] mapped_left;
        logic signed [31:0] mapped_top;
        logic signed [31:0] mapped_right;
        logic signed [31:0] mapped_bottom;
        logic        [9:0]  class_out;
    } result_t;

endpackage

// ----- rtl/dbm_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module dbm_div #(
    parameter int COORD_FRAC_BITS = dbm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic [32+COORD_FRAC_BITS:0]  num,
    input  logic [31:0]                  den,
    output logic [32+COORD_FRAC_BITS:0]  quo
);
    import dbm_pkg::*;

    localparam int NW = 33 + COORD_FRAC_BITS;

    logic [31:0]   rem_reg  [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [31:0]   den_reg  [NW];
    logic [31:0]   rem_next [NW];
    logic [NW-1:0] nq_next  [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_stage
            logic [31:0]   rem_in;
            logic [NW-1:0] nq_in;
            logic [31:0]   den_in;
            logic [32:0]   trial;

            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign nq_in  = num;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign nq_in  = nq_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            // dividend shifts out at the top while quotient bits shift in
            always_comb
            begin
                trial = {rem_in, nq_in[NW-1]};
                if (trial >= {1'b0, den_in})
                begin
                    rem_next[k] = 32'(trial - {1'b0, den_in});
                    nq_next[k]  = {nq_in[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = trial[31:0];
                    nq_next[k]  = {nq_in[NW-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= den_in;
            end
        end
    endgenerate

    assign quo = nq_reg[NW-1];

endmodule

// ----- rtl/detection_box_map_back_top.sv -----
// detection box map-back: normalize, drop, clip, bias and divide pipeline
// a start passes stages 1 to 3, the divider stages and the output register before its result strobes
// throughput: one box per cycle; busy stays low, the divider has one stage per quotient bit
// dropped boxes leave an empty slot in the pipeline and give no result strobe
// reset clears all valid bits and returns the configuration registers to their reset values
// the receiver cannot stall, so the pipeline advances every cycle
module detection_box_map_back_top #(
    parameter int COORD_FRAC_BITS = dbm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dbm_pkg::box_t   box,
    output logic            result_valid,
    output dbm_pkg::result_t result,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data
);
    import dbm_pkg::*;

    localparam int NW = 33 + COORD_FRAC_BITS;
    localparam logic signed [48:0] MAX49 = 49'sd2147483647;
    localparam logic signed [48:0] MIN49 = -49'sd2147483648;

    typedef struct packed {
        logic       bypass;
        logic [3:0] neg;
        box_t       raw;
    } side_t;

    function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
        if (v > MAX49)
            return 32'sh7fff_ffff;
        else if (v < MIN49)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] fin(input logic [NW-1:0] q, input logic neg);
        logic over;
        over = (q[NW-1:31] != '0);
        if (neg)
            return over ? 32'sh8000_0000 : 32'(-q[31:0]);
        else
            return over ? 32'sh7fff_ffff : q[31:0];
    endfunction

    // configuration registers
    logic        norm_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [63:0] vlow_reg;
    logic [63:0] vhigh_reg;
    logic [63:0] offset_reg;
    logic [63:0] ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg   <= 1'b0;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            vlow_reg   <= '0;
            vhigh_reg  <= '0;
            offset_reg <= '0;
            ratio_reg  <= RATIO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NORMALIZED: norm_reg   <= cfg_data[0];
                CFG_IMG_WIDTH:  width_reg  <= cfg_data[15:0];
                CFG_IMG_HEIGHT: height_reg <= cfg_data[15:0];
                CFG_VALID_LOW:  vlow_reg   <= cfg_data;
                CFG_VALID_HIGH: vhigh_reg  <= cfg_data;
                CFG_OFFSET:     offset_reg <= cfg_data;
                CFG_RATIO:      ratio_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [31:0] vx0, vy0, vx1, vy1, bx, by;
    assign vx0 = vlow_reg[31:0];
    assign vy0 = vlow_reg[63:32];
    assign vx1 = vhigh_reg[31:0];
    assign vy1 = vhigh_reg[63:32];
    assign bx  = offset_reg[31:0];
    assign by  = offset_reg[63:32];

    // no stall path: a transfer is taken every cycle
    assign busy = 1'b0;

    // stage 1: normalizing multiply
    logic               s1_vld_reg;
    logic               s1_byp_reg;
    box_t               s1_box_reg;
    logic signed [48:0] s1_prod_reg [4];
    logic signed [16:0] w_s, h_s;

    assign w_s = $signed({1'b0, width_reg});
    assign h_s = $signed({1'b0, height_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_box_reg     <= box;
        s1_byp_reg     <= (ratio_reg[31:0] == '0) || (ratio_reg[63:32] == '0);
        s1_prod_reg[0] <= box.box_left   * w_s;
        s1_prod_reg[1] <= box.box_top    * h_s;
        s1_prod_reg[2] <= box.box_right  * w_s;
        s1_prod_reg[3] <= box.box_bottom * h_s;
    end

    // stage 2: saturate, drop test, clip
    logic signed [31:0] c_x0, c_y0, c_x1, c_y1;
    logic               drop;
    logic               s2_vld_reg;
    logic               s2_byp_reg;
    box_t               s2_box_reg;
    logic signed [31:0] s2_c_reg [4];

    always_comb
    begin
        if (norm_reg)
        begin
            c_x0 = sat49(s1_prod_reg[0]);
            c_y0 = sat49(s1_prod_reg[1]);
            c_x1 = sat49(s1_prod_reg[2]);
            c_y1 = sat49(s1_prod_reg[3]);
        end
        else
        begin
            c_x0 = s1_box_reg.box_left;
            c_y0 = s1_box_reg.box_top;
            c_x1 = s1_box_reg.box_right;
            c_y1 = s1_box_reg.box_bottom;
        end
        drop = !s1_byp_reg && (c_x0 > vx1 || c_y0 > vy1 || c_x1 < vx0 || c_y1 < vy0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg && !drop;
    end

    always_ff @(posedge clk)
    begin
        s2_box_reg  <= s1_box_reg;
        s2_byp_reg  <= s1_byp_reg;
        s2_c_reg[0] <= (c_x0 < vx0) ? vx0 : c_x0;
        s2_c_reg[1] <= (c_y0 < vy0) ? vy0 : c_y0;
        s2_c_reg[2] <= (c_x1 > vx1) ? vx1 : c_x1;
        s2_c_reg[3] <= (c_y1 > vy1) ? vy1 : c_y1;
    end

    // stage 3: subtract bias, split sign and magnitude
    logic               s3_vld_reg;
    side_t              s3_side_reg;
    logic [NW-1:0]      s3_num_reg [4];
    logic signed [32:0] diff [4];
    logic [32:0]        mag  [4];
    logic [3:0]         neg_c;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            diff[i]  = 33'(s2_c_reg[i]) - 33'((i % 2 == 0) ? bx : by);
            neg_c[i] = diff[i][32];
            mag[i]   = neg_c[i] ? 33'(-diff[i]) : 33'(diff[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg.bypass <= s2_byp_reg;
        s3_side_reg.neg    <= neg_c;
        s3_side_reg.raw    <= s2_box_reg;
        for (int i = 0; i < 4; i++)
            s3_num_reg[i] <= {mag[i], {COORD_FRAC_BITS{1'b0}}};
    end

    // divider lanes: x corners by x ratio, y corners by y ratio
    logic [NW-1:0] quo [4];

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            dbm_div #(
                .COORD_FRAC_BITS (COORD_FRAC_BITS)
            ) u_div (
                .clk (clk),
                .num (s3_num_reg[g]),
                .den ((g % 2 == 0) ? ratio_reg[31:0] : ratio_reg[63:32]),
                .quo (quo[g])
            );
        end
    endgenerate

    // sideband travels alongside the divider stages
    logic  vld_reg  [NW];
    side_t side_reg [NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NW; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= s3_vld_reg;
            for (int i = 1; i < NW; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= s3_side_reg;
        for (int i = 1; i < NW; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // output stage
    side_t   sd;
    result_t result_next;
    logic    result_valid_reg;
    result_t result_reg;

    assign sd = side_reg[NW-1];

    always_comb
    begin
        if (sd.bypass)
        begin
            result_next.mapped_left   = sd.raw.box_left;
            result_next.mapped_top    = sd.raw.box_top;
            result_next.mapped_right  = sd.raw.box_right;
            result_next.mapped_bottom = sd.raw.box_bottom;
        end
        else
        begin
            result_next.mapped_left   = fin(quo[0], sd.neg[0]);
            result_next.mapped_top    = fin(quo[1], sd.neg[1]);
            result_next.mapped_right  = fin(quo[2], sd.neg[2]);
            result_next.mapped_bottom = fin(quo[3], sd.neg[3]);
        end
        result_next.class_out = sd.raw.class_tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= vld_reg[NW-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_drop_only_removes: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> $past(s1_vld_reg))
        else $error("stage 2 valid without stage 1 valid");

    a_bypass_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && s1_byp_reg |=> s2_vld_reg)
        else $error("bypassed box was dropped");

    a_class_kept: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NW-1] |=> result_valid && result.class_out == $past(sd.raw.class_tag))
        else $error("class id not carried to the result");
`endif

endmodule

// ----- tb/detection_box_map_back_top_tb.sv -----
// testbench for the detection box map-back block with a built-in predictor
`timescale 1ns / 1ps

module detection_box_map_back_top_tb;
    import dbm_pkg::*;

    localparam int FRAC = COORD_FRAC_BITS_DEF;
    localparam int LATENCY = 37 + FRAC;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    box_t        box;
    logic        result_valid;
    result_t     result;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // predictor copy of the registers
    logic        m_norm;
    logic [15:0] m_width;
    logic [15:0] m_height;
    logic [63:0] m_vlow;
    logic [63:0] m_vhigh;
    logic [63:0] m_offset;
    logic [63:0] m_ratio;

    result_t mapped_q[$];
    int      err_count;
    bit      quiet;

    detection_box_map_back_top i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .box(box),
        .result_valid(result_valid), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        err_count++;
    endtask

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [31:0] rescale(input logic signed [63:0] c,
                                                   input logic signed [63:0] bias,
                                                   input logic [31:0] ratio);
        logic signed [63:0] diff;
        logic [63:0]        mag;
        logic [63:0]        q;
        diff = c - bias;
        mag = diff < 0 ? -diff : diff;
        q = (mag << FRAC) / {32'd0, ratio};
        if (q > 64'h8000_0000)
            q = 64'h8000_0000;
        return 32'(clamp32(diff < 0 ? -$signed(q) : $signed(q)));
    endfunction

    // returns 0 when the box falls outside the valid region; a zero ratio passes the box through
    function automatic bit map_box(input box_t b, output result_t r);
        logic signed [63:0] x0, y0, x1, y1, vx0, vy0, vx1, vy1;
        logic [31:0] rx, ry;
        x0 = b.box_left;
        y0 = b.box_top;
        x1 = b.box_right;
        y1 = b.box_bottom;
        rx = m_ratio[31:0];
        ry = m_ratio[63:32];
        r.class_out = b.class_tag;
        if (rx == 0 || ry == 0)
        begin
            r.mapped_left = b.box_left;
            r.mapped_top = b.box_top;
            r.mapped_right = b.box_right;
            r.mapped_bottom = b.box_bottom;
            return 1;
        end
        vx0 = $signed(m_vlow[31:0]);
        vy0 = $signed(m_vlow[63:32]);
        vx1 = $signed(m_vhigh[31:0]);
        vy1 = $signed(m_vhigh[63:32]);
        if (m_norm)
        begin
            x0 = clamp32(x0 * $signed({48'd0, m_width}));
            x1 = clamp32(x1 * $signed({48'd0, m_width}));
            y0 = clamp32(y0 * $signed({48'd0, m_height}));
            y1 = clamp32(y1 * $signed({48'd0, m_height}));
        end
        if (x0 > vx1 || y0 > vy1 || x1 < vx0 || y1 < vy0)
            return 0;
        if (x0 < vx0) x0 = vx0;
        if (x1 > vx1) x1 = vx1;
        if (y0 < vy0) y0 = vy0;
        if (y1 > vy1) y1 = vy1;
        r.mapped_left = rescale(x0, $signed(m_offset[31:0]), rx);
        r.mapped_right = rescale(x1, $signed(m_offset[31:0]), rx);
        r.mapped_top = rescale(y0, $signed(m_offset[63:32]), ry);
        r.mapped_bottom = rescale(y1, $signed(m_offset[63:32]), ry);
        return 1;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t exp;
        if (rst_n && result_valid)
        begin
            if (mapped_q.size() == 0)
            begin
                report("unexpected result", 32'(result.class_out), 32'd0);
            end
            else
            begin
                exp = mapped_q.pop_front();
                if (result.mapped_left !== exp.mapped_left)
                    report("left", result.mapped_left, exp.mapped_left);
                if (result.mapped_top !== exp.mapped_top)
                    report("top", result.mapped_top, exp.mapped_top);
                if (result.mapped_right !== exp.mapped_right)
                    report("right", result.mapped_right, exp.mapped_right);
                if (result.mapped_bottom !== exp.mapped_bottom)
                    report("bottom", result.mapped_bottom, exp.mapped_bottom);
                if (result.class_out !== exp.class_out)
                    report("class", 32'(result.class_out), 32'(exp.class_out));
            end
        end
    end

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (mapped_q.size() != 0 && guard < 10000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NORMALIZED: m_norm = val[0];
            CFG_IMG_WIDTH:  m_width = val[15:0];
            CFG_IMG_HEIGHT: m_height = val[15:0];
            CFG_VALID_LOW:  m_vlow = val;
            CFG_VALID_HIGH: m_vhigh = val;
            CFG_OFFSET:     m_offset = val;
            CFG_RATIO:      m_ratio = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic send_box(input box_t b);
        result_t r;
        if (!quiet && $urandom_range(99) < 6)
        begin
            start <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < 6)
                @(negedge clk);
        end
        start <= 1'b1;
        box <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (map_box(b, r))
            mapped_q = {mapped_q, r};
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
        endcase
    endfunction

    function automatic box_t rand_box(input bit normal);
        box_t b;
        logic signed [31:0] a, c;
        b.box_left = rand_coord();
        b.box_top = rand_coord();
        b.box_right = rand_coord();
        b.box_bottom = rand_coord();
        if (normal)
        begin
            a = $urandom_range(0, 32'h0001_0000);
            c = $urandom_range(0, 32'h0001_0000);
            b.box_left = a; b.box_right = a + $urandom_range(0, 32'h8000);
            b.box_top = c; b.box_bottom = c + $urandom_range(0, 32'h8000);
        end
        b.class_tag = 10'($urandom());
        return b;
    endfunction

    task automatic test_directed();
        box_t b;
        b = '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 10'd0};
        send_box(b);
        b = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 10'h3ff};
        send_box(b);
        drain();
        // wide valid region, negative and saturating quotients
        write_reg(CFG_VALID_LOW, {32'h8000_0000, 32'h8000_0000});
        write_reg(CFG_VALID_HIGH, {32'h7fff_ffff, 32'h7fff_ffff});
        write_reg(CFG_OFFSET, {32'h7fff_ffff, 32'h8000_0000});
        write_reg(CFG_RATIO, {32'h0000_0001, 32'hffff_ffff});
        send_box('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 10'h155});
        send_box('{32'sh1234_5678, 32'sh8765_4321, 32'sh0000_0001, 32'shffff_ffff, 10'h2aa});
        drain();
        // drop on each side of the region
        write_reg(CFG_OFFSET, 64'd0);
        write_reg(CFG_RATIO, RATIO_RESET);
        write_reg(CFG_VALID_LOW, {32'h0001_0000, 32'h0001_0000});
        write_reg(CFG_VALID_HIGH, {32'h0010_0000, 32'h0010_0000});
        send_box('{32'sh0011_0000, 32'sh0002_0000, 32'sh0012_0000, 32'sh0003_0000, 10'd1});
        send_box('{32'sh0002_0000, 32'sh0011_0000, 32'sh0003_0000, 32'sh0012_0000, 10'd2});
        send_box('{32'sh0000_0000, 32'sh0002_0000, 32'sh0000_ffff, 32'sh0003_0000, 10'd3});
        send_box('{32'sh0002_0000, 32'sh0000_0000, 32'sh0003_0000, 32'sh0000_ffff, 10'd4});
        // clipping on all edges, and touching edges
        send_box('{32'sh0000_0000, 32'sh0000_0000, 32'sh0020_0000, 32'sh0020_0000, 10'd5});
        send_box('{32'sh0010_0000, 32'sh0010_0000, 32'sh0001_0000, 32'sh0001_0000, 10'd6});
        drain();
        // normalized scaling with saturation
        write_reg(CFG_NORMALIZED, 64'd1);
        write_reg(CFG_IMG_WIDTH, 64'hffff);
        write_reg(CFG_IMG_HEIGHT, 64'd0);
        write_reg(CFG_VALID_LOW, {32'h8000_0000, 32'h8000_0000});
        write_reg(CFG_VALID_HIGH, {32'h7fff_ffff, 32'h7fff_ffff});
        send_box('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 10'd7});
        send_box('{32'sh0000_8000, 32'sh0000_8000, 32'sh0001_0000, 32'sh0001_0000, 10'd8});
        drain();
        // either ratio zero passes the box through
        write_reg(CFG_RATIO, {32'h0001_0000, 32'h0000_0000});
        send_box('{32'sh8000_0000, 32'sh1111_1111, 32'sh7fff_ffff, 32'sh2222_2222, 10'd9});
        drain();
        write_reg(CFG_RATIO, {32'h0000_0000, 32'h0001_0000});
        send_box('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'shffff_ffff, 10'd10});
        drain();
        // unused index is ignored
        write_reg(CFG_UNUSED, 64'hffff_ffff_ffff_ffff);
        send_box('{32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0003, 32'sh0000_0004, 10'd11});
        drain();
    endtask

    task automatic test_random(input int count, input bit no_gaps);
        quiet = no_gaps;
        for (int i = 0; i < count; i++)
            send_box(rand_box($urandom_range(99) < 70));
        quiet = 1'b0;
    endtask

    task automatic random_config();
        logic [31:0] lx, ly;
        lx = $urandom_range(0, 32'h0002_0000);
        ly = $urandom_range(0, 32'h0002_0000);
        write_reg(CFG_NORMALIZED, 64'($urandom_range(1)));
        write_reg(CFG_IMG_WIDTH, $urandom_range(0, 3) == 0 ? 64'($urandom()) :
                  64'($urandom_range(1, 4)));
        write_reg(CFG_IMG_HEIGHT, $urandom_range(0, 3) == 0 ? 64'($urandom()) :
                  64'($urandom_range(1, 4)));
        write_reg(CFG_VALID_LOW, {ly - 32'h0001_0000, lx - 32'h0001_0000});
        write_reg(CFG_VALID_HIGH, {ly + 32'h0004_0000, lx + 32'h0004_0000});
        write_reg(CFG_OFFSET, {32'($urandom_range(0, 32'h0002_0000)), $urandom()});
        write_reg(CFG_RATIO, $urandom_range(0, 9) == 0 ? 64'd0 :
                  {32'($urandom_range(1, 32'h0004_0000)), 32'($urandom_range(1, 32'h0004_0000))});
    endtask

    initial
    begin
        err_count = 0;
        quiet = 1'b0;
        start = 1'b0;
        box = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_NORMALIZED;
        cfg_data = '0;
        m_norm = 1'b0;
        m_width = 16'd1;
        m_height = 16'd1;
        m_vlow = '0;
        m_vhigh = '0;
        m_offset = '0;
        m_ratio = RATIO_RESET;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        for (int p = 0; p < 12; p++)
        begin
            random_config();
            test_random(120, p == 3);
            drain();
        end
        // extreme random values on the full range
        write_reg(CFG_NORMALIZED, 64'd0);
        write_reg(CFG_RATIO, {32'hffff_ffff, 32'h0000_0001});
        write_reg(CFG_VALID_LOW, {32'h8000_0000, 32'h8000_0000});
        write_reg(CFG_VALID_HIGH, {32'h7fff_ffff, 32'h7fff_ffff});
        write_reg(CFG_OFFSET, {32'($urandom()), 32'($urandom())});
        test_random(40, 1'b0);
        drain();

        if (err_count == 0 && mapped_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
